>>> sv/tira_pkg.sv
`timescale 1ns / 1ps

package tira_pkg;

    localparam int RANGE_W = 7;
    localparam int ADDR_W  = 32;
    localparam int NUM_RANGE_CODES = 128;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_BUILD   = 3'd1,
        OP_PROPOSE = 3'd2,
        OP_BIND    = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_RELEASE = 3'd5,
        OP_FLUSH   = 3'd6
    } t_op;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [1:0] {
        PUSH_IDX   = 2'd0,
        PUSH_BLK   = 2'd1,
        PUSH_ALLOC = 2'd2
    } t_push_sel;

    typedef struct packed {
        logic      latch;
        logic      idx_clr;
        logic      idx_inc;
        logic      rd_en;
        logic      push;
        t_push_sel push_sel;
        logic      shift_wr;
        logic      q_dec;
        logic      bmap_clr;
        logic      bmap_set;
        logic      blk_load;
        logic      blk_clr;
        logic      alloc_write;
        logic      alloc_free;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         op;
        logic               inb;
        logic               addr_zero;
        logic               rbits_zero;
        logic               fcnt_zero;
        logic               fcnt_full;
        logic               bcnt_full;
        logic               idx_lt_fcnt;
        logic               idx_lt_bcnt;
        logic               idx_lt_peers;
        logic               idx_lt_n;
        logic               rd_vld;
        logic               a_hit;
        logic               b_hit;
        logic               q_hit;
        logic               slot_found;
        logic               bmap_hit;
        logic [RANGE_W-1:0] q_rdata;
        logic [RANGE_W-1:0] a_range;
        logic [RANGE_W-1:0] b_range;
    } t_stat;

    function automatic logic [7:0] range_count(input logic [2:0] bits);
        logic [7:0] n;
        n = (bits == 3'd0) ? 8'd0 : (8'd1 << bits);
        return n;
    endfunction

endpackage

>>> sv/tira_dp.sv
`timescale 1ns / 1ps

module tira_dp #(
    parameter int MAX_RANGES = 128,
    parameter int MAX_PEERS  = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tira_pkg::t_cmd                  i_cmd,
    input  logic [2:0]                      i_range_bits,
    input  logic [2:0]                      i_op,
    input  logic                            i_inb,
    input  logic [tira_pkg::ADDR_W-1:0]     i_addr,
    input  logic [tira_pkg::RANGE_W-1:0]    i_rin,
    output tira_pkg::t_stat                 o_stat
);

    localparam int RW  = tira_pkg::RANGE_W;
    localparam int AW  = tira_pkg::ADDR_W;
    localparam int EW  = AW + RW;
    localparam int QAW = $clog2(MAX_RANGES);
    localparam int PAW = $clog2(MAX_PEERS);
    localparam int FW  = $clog2(MAX_RANGES + 1);
    localparam int BW  = $clog2(MAX_PEERS + 1);
    localparam int NR  = tira_pkg::NUM_RANGE_CODES;
    localparam int IW  = $clog2(((MAX_PEERS > NR) ? MAX_PEERS : NR) + 1);

    logic [AW-1:0]        r_addr;
    logic [RW-1:0]        r_rin;
    logic [2:0]           r_op;
    logic                 r_inb;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_idx_d;
    logic                 r_rd_vld;
    logic [FW-1:0]        r_fcnt;
    logic [BW-1:0]        r_bcnt;
    logic [MAX_PEERS-1:0] r_valid;
    logic                 r_valid_d;
    logic [NR-1:0]        r_bmap;
    logic [PAW-1:0]       r_slot;
    logic                 r_slot_found;

    logic [RW-1:0] m_q [MAX_RANGES];
    logic [EW-1:0] m_a [MAX_PEERS];
    logic [EW-1:0] m_b [MAX_PEERS];
    logic [RW-1:0] r_qd;
    logic [EW-1:0] r_ad;
    logic [EW-1:0] r_bd;

    logic [RW-1:0] push_data;
    logic          fcnt_full;
    logic          bcnt_full;
    logic [IW-1:0] shift_idx;

    assign fcnt_full = (r_fcnt >= FW'(MAX_RANGES));
    assign bcnt_full = (r_bcnt >= BW'(MAX_PEERS));
    assign shift_idx = r_idx_d - IW'(1);

    always_comb begin
        case (i_cmd.push_sel)
            tira_pkg::PUSH_BLK:   push_data = r_bd[RW-1:0];
            tira_pkg::PUSH_ALLOC: push_data = r_ad[RW-1:0];
            default:              push_data = r_idx[RW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_addr <= i_addr;
            r_rin  <= i_rin;
            r_op   <= i_op;
            r_inb  <= i_inb;
        end
        if (i_cmd.rd_en) begin
            r_qd      <= m_q[r_idx[QAW-1:0]];
            r_ad      <= m_a[r_idx[PAW-1:0]];
            r_bd      <= m_b[r_idx[PAW-1:0]];
            r_valid_d <= r_valid[r_idx[PAW-1:0]];
        end
        r_idx_d <= r_idx;
        if (i_cmd.push && !fcnt_full) begin
            m_q[r_fcnt[QAW-1:0]] <= push_data;
        end else if (i_cmd.shift_wr) begin
            m_q[shift_idx[QAW-1:0]] <= r_qd;
        end
        if (i_cmd.alloc_write) begin
            m_a[r_slot] <= {r_addr, r_rin};
        end
        if (i_cmd.blk_load && !bcnt_full) begin
            m_b[r_bcnt[PAW-1:0]] <= {r_addr, r_rin};
        end
        if (i_cmd.latch) begin
            r_slot <= '0;
        end else if (i_cmd.rd_en && !r_slot_found && !r_valid[r_idx[PAW-1:0]]) begin
            r_slot <= r_idx[PAW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_fcnt       <= '0;
            r_bcnt       <= '0;
            r_valid      <= '0;
            r_bmap       <= '0;
            r_slot_found <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.push && !fcnt_full) begin
                r_fcnt <= r_fcnt + FW'(1);
            end else if (i_cmd.q_dec) begin
                r_fcnt <= r_fcnt - FW'(1);
            end
            if (i_cmd.blk_clr) begin
                r_bcnt <= '0;
            end else if (i_cmd.blk_load && !bcnt_full) begin
                r_bcnt <= r_bcnt + BW'(1);
            end
            if (i_cmd.alloc_write) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.alloc_free) begin
                r_valid[r_idx_d[PAW-1:0]] <= 1'b0;
            end
            if (i_cmd.bmap_clr) begin
                r_bmap <= '0;
            end else if (i_cmd.bmap_set) begin
                r_bmap[r_bd[RW-1:0]] <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_slot_found <= 1'b0;
            end else if (i_cmd.rd_en && !r_valid[r_idx[PAW-1:0]]) begin
                r_slot_found <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.inb          = r_inb;
        o_stat.addr_zero    = (r_addr == '0);
        o_stat.rbits_zero   = (i_range_bits == 3'd0);
        o_stat.fcnt_zero    = (r_fcnt == '0);
        o_stat.fcnt_full    = fcnt_full;
        o_stat.bcnt_full    = bcnt_full;
        o_stat.idx_lt_fcnt  = (r_idx < IW'(r_fcnt));
        o_stat.idx_lt_bcnt  = (r_idx < IW'(r_bcnt));
        o_stat.idx_lt_peers = (r_idx < IW'(MAX_PEERS));
        o_stat.idx_lt_n     = (r_idx < IW'(tira_pkg::range_count(i_range_bits)));
        o_stat.rd_vld       = r_rd_vld;
        o_stat.a_hit        = r_rd_vld && r_valid_d && (r_ad[EW-1:RW] == r_addr);
        o_stat.b_hit        = r_rd_vld && (r_bd[EW-1:RW] == r_addr);
        o_stat.q_hit        = r_rd_vld && (r_qd == r_rin);
        o_stat.slot_found   = r_slot_found;
        o_stat.bmap_hit     = r_bmap[r_idx[RW-1:0]];
        o_stat.q_rdata      = r_qd;
        o_stat.a_range      = r_ad[RW-1:0];
        o_stat.b_range      = r_bd[RW-1:0];
    end

endmodule

>>> sv/tira_ctrl.sv
`timescale 1ns / 1ps

module tira_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,  // range_out, zero pad
    output logic [3:0]      o_m_tuser,  // status, found
    input  tira_pkg::t_stat i_stat,
    output tira_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_BMAP, S_BUILD, S_PROPW, S_AFIND, S_BFIND,
        S_FLUSH, S_QRM, S_SHIFT, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_st, n_st;
    logic [6:0] r_rout, n_rout;
    logic       r_found, n_found;
    logic       r_full, n_full;
    logic       r_ovalid, n_ovalid;
    logic [2:0] r_ost, n_ost;
    logic [6:0] r_orout, n_orout;
    logic       r_ofound, n_ofound;
    logic       scan_end;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_orout};
    assign o_m_tuser  = {r_ofound, r_ost};

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_st     = r_st;
        n_rout   = r_rout;
        n_found  = r_found;
        n_full   = r_full;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ost    = r_ost;
        n_orout  = r_orout;
        n_ofound = r_ofound;
        scan_end = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_st          = tira_pkg::ST_OK;
                    n_rout        = '0;
                    n_found       = 1'b0;
                    n_full        = 1'b0;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    tira_pkg::OP_LOAD: begin
                        o_cmd.blk_load = 1'b1;
                        if (i_stat.bcnt_full) n_st = tira_pkg::ST_FULL;
                        n_state = S_DONE;
                    end
                    tira_pkg::OP_BUILD: begin
                        o_cmd.bmap_clr = 1'b1;
                        n_state = S_BMAP;
                    end
                    tira_pkg::OP_PROPOSE: begin
                        if (i_stat.rbits_zero) begin
                            n_state = S_DONE;
                        end else if (i_stat.fcnt_zero) begin
                            n_st    = tira_pkg::ST_NONE;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_PROPW;
                        end
                    end
                    tira_pkg::OP_BIND, tira_pkg::OP_RELEASE: begin
                        if (i_stat.addr_zero) begin
                            n_st    = tira_pkg::ST_ZERO;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_AFIND;
                        end
                    end
                    tira_pkg::OP_LOOKUP: begin
                        n_state = i_stat.inb ? S_BFIND : S_AFIND;
                    end
                    tira_pkg::OP_FLUSH: begin
                        n_state = S_FLUSH;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BMAP: begin
                o_cmd.rd_en    = i_stat.idx_lt_bcnt;
                o_cmd.idx_inc  = i_stat.idx_lt_bcnt;
                o_cmd.bmap_set = i_stat.rd_vld;
                if (!i_stat.idx_lt_bcnt && !i_stat.rd_vld) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_BUILD;
                end
            end
            S_BUILD: begin
                if (i_stat.idx_lt_n) begin
                    o_cmd.idx_inc = 1'b1;
                    if (!i_stat.bmap_hit) begin
                        o_cmd.push     = 1'b1;
                        o_cmd.push_sel = tira_pkg::PUSH_IDX;
                        if (i_stat.fcnt_full) n_full = 1'b1;
                    end
                end else begin
                    if (r_full) n_st = tira_pkg::ST_FULL;
                    n_state = S_DONE;
                end
            end
            S_PROPW: begin
                n_rout  = i_stat.q_rdata;
                n_state = S_DONE;
            end
            S_AFIND: begin
                o_cmd.rd_en   = i_stat.idx_lt_peers;
                o_cmd.idx_inc = i_stat.idx_lt_peers;
                scan_end      = !i_stat.idx_lt_peers && !i_stat.rd_vld;
                if (i_stat.a_hit) begin
                    n_state = S_DONE;
                    if (i_stat.op == tira_pkg::OP_LOOKUP) begin
                        n_rout  = i_stat.a_range;
                        n_found = 1'b1;
                    end else if (i_stat.op == tira_pkg::OP_RELEASE) begin
                        if (i_stat.fcnt_full) begin
                            n_st = tira_pkg::ST_FULL;
                        end else begin
                            o_cmd.push       = 1'b1;
                            o_cmd.push_sel   = tira_pkg::PUSH_ALLOC;
                            o_cmd.alloc_free = 1'b1;
                        end
                    end
                end else if (scan_end) begin
                    if (i_stat.op == tira_pkg::OP_BIND) begin
                        if (i_stat.slot_found) begin
                            o_cmd.alloc_write = 1'b1;
                            o_cmd.idx_clr     = 1'b1;
                            n_state           = S_QRM;
                        end else begin
                            n_st    = tira_pkg::ST_FULL;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_st    = tira_pkg::ST_NOTFOUND;
                        n_state = S_DONE;
                    end
                end
            end
            S_BFIND: begin
                o_cmd.rd_en   = i_stat.idx_lt_bcnt;
                o_cmd.idx_inc = i_stat.idx_lt_bcnt;
                if (i_stat.b_hit) begin
                    n_rout  = i_stat.b_range;
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (!i_stat.idx_lt_bcnt && !i_stat.rd_vld) begin
                    n_st    = tira_pkg::ST_NOTFOUND;
                    n_state = S_DONE;
                end
            end
            S_FLUSH: begin
                o_cmd.rd_en   = i_stat.idx_lt_bcnt;
                o_cmd.idx_inc = i_stat.idx_lt_bcnt;
                if (i_stat.rd_vld) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = tira_pkg::PUSH_BLK;
                    if (i_stat.fcnt_full) n_full = 1'b1;
                end else if (!i_stat.idx_lt_bcnt) begin
                    o_cmd.blk_clr = 1'b1;
                    if (r_full) n_st = tira_pkg::ST_FULL;
                    n_state = S_DONE;
                end
            end
            S_QRM: begin
                o_cmd.rd_en   = i_stat.idx_lt_fcnt;
                o_cmd.idx_inc = i_stat.idx_lt_fcnt;
                if (i_stat.q_hit) begin
                    n_state = S_SHIFT;
                end else if (!i_stat.idx_lt_fcnt && !i_stat.rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.rd_en    = i_stat.idx_lt_fcnt;
                o_cmd.idx_inc  = i_stat.idx_lt_fcnt;
                o_cmd.shift_wr = i_stat.rd_vld;
                if (!i_stat.idx_lt_fcnt && !i_stat.rd_vld) begin
                    o_cmd.q_dec = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_st;
                    n_orout  = r_rout;
                    n_ofound = r_found;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_full   <= n_full;
        end
        r_st     <= n_st;
        r_rout   <= n_rout;
        r_found  <= n_found;
        r_ost    <= n_ost;
        r_orout  <= n_orout;
        r_ofound <= n_ofound;
    end

endmodule

>>> sv/tunnel_id_range_allocator_top.sv
`timescale 1ns / 1ps

// Allocates tunnel-ID ranges to peer nodes. Commands arrive one word at a time on the
// slave stream and each one yields exactly one result word on the master stream.
// The range_bits register is to be written through the APB port only while the block
// is idle; the block itself does not enforce this. A controller sequences each
// command; the datapath holds the free queue, the allocated-peer table and the
// blocked list in memories, walked one entry per cycle with registered read data.
// Per command: load, propose and unused codes walk no memory; lookup walks the table,
// or the blocked list when in_blocked is set; release walks the table; bind walks the
// table and then compacts the free queue; build walks the blocked list and then the
// range codes; flush walks the blocked list. One command is in flight.
// The result register frees the slave side, so the next command is accepted while a
// result waits; a stalled receiver holds the finished result in the controller.
// Reset empties the free queue, the blocked list and the table, and clears range_bits.
module tunnel_id_range_allocator_top #(
    parameter int MAX_RANGES = 128,
    parameter int MAX_PEERS  = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // peer address, range_in, zero pad
    input  logic [3:0]  i_s_tuser,  // op, in_blocked
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // range_out, zero pad
    output logic [3:0]  o_m_tuser,  // status, found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]      r_range_bits;
    tira_pkg::t_cmd  cmd;
    tira_pkg::t_stat stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_range_bits} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_bits <= 3'd0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_range_bits <= pwdata[2:0];
        end
    end

    tira_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tira_dp #(
        .MAX_RANGES (MAX_RANGES),
        .MAX_PEERS  (MAX_PEERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_range_bits (r_range_bits),
        .i_op         (i_s_tuser[2:0]),
        .i_inb        (i_s_tuser[3]),
        .i_addr       (i_s_tdata[31:0]),
        .i_rin        (i_s_tdata[38:32]),
        .o_stat       (stat)
    );

endmodule
